[design/ippc_pkg.sv]
`timescale 1ns / 1ps

package ippc_pkg;

	localparam int ADDR_W = 32;
	localparam int PLEN_W = 6;
	localparam int IDX_W  = 5;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_CLEAR  = 2'd2
	} opcode_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [PLEN_W-1:0] prefix;
		logic              policy;
	} rule_t;

	typedef struct packed {
		logic  en;
		rule_t rule;
	} wr_t;

	typedef struct packed {
		logic [ADDR_W-1:0] key;
		logic              found;
		logic [IDX_W-1:0]  idx;
		logic              verdict;
	} tok_t;

	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
		logic [ADDR_W-1:0] m;
		if (plen >= PLEN_W'(ADDR_W)) begin
			m = '1;
		end else begin
			m = ~({ADDR_W{1'b1}} >> plen);
		end
		return m;
	endfunction

endpackage

[design/ippc_cell.sv]
`timescale 1ns / 1ps

module ippc_cell import ippc_pkg::*; #(
	parameter int IDX   = 0,
	parameter int CNT_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] count,
	input  wr_t              wr,
	input  logic             in_valid,
	input  tok_t             in_tok,
	output logic             out_valid,
	output tok_t             out_tok
);

	rule_t             rule_q;
	logic              valid_q;
	tok_t              tok_q;
	logic              active;
	logic              hit;
	logic [ADDR_W-1:0] mask;
	tok_t              tok_d;

	// rule slot, written on append when it is the tail
	always_ff @(posedge clk) begin
		if (wr.en && count == CNT_W'(IDX)) begin
			rule_q <= wr.rule;
		end
	end

	assign active = count > CNT_W'(IDX);
	assign mask   = prefix_mask(rule_q.prefix);
	assign hit    = active && ((in_tok.key & mask) == (rule_q.addr & mask));

	always_comb begin
		tok_d = in_tok;
		if (!in_tok.found && hit) begin
			tok_d.found   = 1'b1;
			tok_d.idx     = IDX_W'(IDX);
			tok_d.verdict = ~rule_q.policy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	assign out_valid = valid_q;
	assign out_tok   = tok_q;

endmodule

[design/ipv4_prefix_policy_classifier.sv]
`timescale 1ns / 1ps
// append, clear and unused codes: result strobed in the cycle after the accepting edge,
// busy stays low, so one such transaction per cycle while no lookup holds busy high
// lookup: the key steps through one rule cell per cycle, result strobed as the key leaves
// the last cell, busy while the lookup is in flight, next lookup taken only after that result
// reset empties the table and drops any lookup in flight; rule contents are not cleared

module ipv4_prefix_policy_classifier import ippc_pkg::*; #(
	parameter int MAX_RULES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] address,
	input  logic [5:0]  prefix_len,
	input  logic        policy_bit,
	output logic        strobe,
	output logic        apply_verdict,
	output logic        rule_matched,
	output logic [4:0]  matched_index,
	output logic        status
);

	localparam int CNT_W = $clog2(MAX_RULES + 1);

	logic [CNT_W-1:0]   count_q;
	logic               busy_q;
	logic               nl_strobe_q;
	logic               nl_status_q;
	logic               accept;
	logic               full;
	wr_t                wr;
	logic [MAX_RULES:0] chain_valid;
	tok_t               chain_tok [0:MAX_RULES];
	logic [PLEN_W-1:0]  plen_sat;
	opcode_t            op;

	assign op     = opcode_t'(opcode);
	assign accept = start && !busy_q;
	assign full   = count_q >= CNT_W'(MAX_RULES);

	assign plen_sat = (prefix_len > PLEN_W'(ADDR_W)) ? PLEN_W'(ADDR_W) : prefix_len;

	assign wr.en          = accept && op == OP_APPEND && !full;
	assign wr.rule.addr   = address;
	assign wr.rule.prefix = plen_sat;
	assign wr.rule.policy = policy_bit;

	assign chain_valid[0]       = accept && op == OP_LOOKUP;
	assign chain_tok[0].key     = address;
	assign chain_tok[0].found   = 1'b0;
	assign chain_tok[0].idx     = '0;
	assign chain_tok[0].verdict = 1'b0;

	for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
		ippc_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.count     (count_q),
			.wr        (wr),
			.in_valid  (chain_valid[i]),
			.in_tok    (chain_tok[i]),
			.out_valid (chain_valid[i+1]),
			.out_tok   (chain_tok[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			nl_strobe_q <= 1'b0;
		end else begin
			nl_strobe_q <= accept && op != OP_LOOKUP;
			if (chain_valid[MAX_RULES]) begin
				busy_q <= 1'b0;
			end else if (accept && op == OP_LOOKUP) begin
				busy_q <= 1'b1;
			end
			if (accept) begin
				case (op)
					OP_APPEND: begin
						if (!full) begin
							count_q <= count_q + 1'b1;
						end
					end
					OP_CLEAR: begin
						count_q <= '0;
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		nl_status_q <= op == OP_APPEND && full;
	end

	assign busy          = busy_q;
	assign strobe        = nl_strobe_q | chain_valid[MAX_RULES];
	assign apply_verdict = chain_valid[MAX_RULES] & chain_tok[MAX_RULES].verdict;
	assign rule_matched  = chain_valid[MAX_RULES] & chain_tok[MAX_RULES].found;
	assign matched_index = chain_valid[MAX_RULES] ? chain_tok[MAX_RULES].idx : '0;
	assign status        = nl_strobe_q & nl_status_q;

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(nl_strobe_q && chain_valid[MAX_RULES]))
		else $error("two results in one cycle");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chain_valid[MAX_RULES:1]))
		else $error("more than one lookup in the cell row");

	a_busy_token: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (|chain_valid[MAX_RULES:1]))
		else $error("busy out of step with lookup in flight");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RULES))
		else $error("rule count beyond table size");

endmodule
